>>> src/base64_encoder_custom_alphabet_macros.svh
// Assertion macros for the base64 encoder.
// Included by the top level; depends on nothing else.
`ifndef BASE64_ENCODER_CUSTOM_ALPHABET_MACROS_SVH
`define BASE64_ENCODER_CUSTOM_ALPHABET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
package b64e_pkg;

	// Padding character '='.
	localparam logic [7:0] PAD_CHAR = 8'd61;

	// Permuted alphabet, first character in the most significant byte.
	localparam logic [8*64-1:0] ALPHABET_STR =
		"QWERTYUIOPASDFGHJKLZXCVBNMqwertyuiopasdfghjklzxcvbn/+m1234567890";

	// Bytes held of the current group.
	localparam logic [1:0] PHASE_EMPTY = 2'd0;
	localparam logic [1:0] PHASE_ONE   = 2'd1;
	localparam logic [1:0] PHASE_TWO   = 2'd2;

	// Index of the final character within a group.
	localparam logic [1:0] LAST_SLOT = 2'd3;

	// One group of four encoded characters, first character in slot 0.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            last;
	} grp_t;

	// Map a 6-bit symbol to its alphabet character.
	function automatic logic [7:0] sym_char(input logic [5:0] sym);
		logic [5:0] rev;
		rev = 6'd63 - sym;
		return ALPHABET_STR[{rev, 3'b000} +: 8];
	endfunction

endpackage

>>> src/b64e_if.sv
// Channel interfaces for the base64 encoder: raw bytes in, characters out.
// Depends on nothing but the language.
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

>>> src/base64_encoder_custom_alphabet.sv
// Top level of the base64 encoder with a permuted alphabet.
// Depends on b64e_pkg, b64e_if, b64e_pack, b64e_emit and the macros header.
//
//  Channel    Dir  Payload               Transfer
//  byte_in    in   data_byte, last_byte  valid && ready
//  char_out   out  out_char, last_char   valid && ready
//
// Each byte is taken on a byte_in transfer; a byte that completes a group, or
// ends the message, loads four characters, which leave at one per cycle while
// char_out.ready is high. The single-character output port sets the sustained
// rate. The first character of a group appears once the group has passed
// through the group register and been loaded into the emitter. Reset clears
// the group phase, the held bytes and both valid flags. A stalled output holds
// its character while one further group waits in the group register.
`include "base64_encoder_custom_alphabet_macros.svh"

module base64_encoder_custom_alphabet (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   byte_in,
	b64e_char_if.source char_out
);
	import b64e_pkg::*;

	grp_t grp;
	logic grp_valid;
	logic grp_ready;

	// Grouping and mapping stage.
	b64e_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready)
	);

	// Character serialiser.
	b64e_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.char_out  (char_out)
	);

	// A message-ending byte always leaves a group waiting for the emitter.
	`B64E_ASSERT_NEXT(a_last_makes_group, clk, arst_n,
		byte_in.valid && byte_in.ready && byte_in.last_byte,
		grp_valid && grp.last, "last byte did not produce a flagged group")

	// A group held back by the emitter must not change.
	`B64E_ASSERT_NEXT(a_group_holds, clk, arst_n,
		grp_valid && !grp_ready,
		grp_valid && $stable(grp), "waiting group changed or was lost")

endmodule

>>> src/b64e_pack.sv
// Byte grouping and symbol mapping: collects bytes into groups of three
// and registers four encoded characters. Depends on b64e_pkg and b64e_if.
module b64e_pack (
	input  logic             clk,
	input  logic             arst_n,
	b64e_byte_if.sink        byte_in,
	output b64e_pkg::grp_t   grp,
	output logic             grp_valid,
	input  logic             grp_ready
);
	import b64e_pkg::*;

	logic [1:0]  phase_q;
	logic [15:0] held_q;
	grp_t        grp_q;
	logic        grp_valid_q;

	logic [1:0]  phase;
	logic        accept;
	logic        emit;
	logic [23:0] word;
	grp_t        grp_d;

	// A new byte may enter whenever the group register is free or being drained.
	assign byte_in.ready = !grp_valid_q || grp_ready;
	assign accept = byte_in.valid && byte_in.ready;

	// An unused phase code behaves as an empty group.
	assign phase = (phase_q == 2'd3) ? PHASE_EMPTY : phase_q;
	assign emit  = (phase == PHASE_TWO) || byte_in.last_byte;

	// Assemble the 24-bit word; missing low bytes of a short group are zero.
	always_comb begin
		case (phase)
			PHASE_TWO: word = {held_q, byte_in.data_byte};
			PHASE_ONE: word = {held_q[7:0], byte_in.data_byte, 8'd0};
			default:   word = {byte_in.data_byte, 16'd0};
		endcase
	end

	// Map the four symbols and insert padding for a short final group.
	always_comb begin
		grp_d.chars[0] = sym_char(word[23:18]);
		grp_d.chars[1] = sym_char(word[17:12]);
		grp_d.chars[2] = (phase == PHASE_EMPTY) ? PAD_CHAR : sym_char(word[11:6]);
		grp_d.chars[3] = (phase == PHASE_TWO) ? sym_char(word[5:0]) : PAD_CHAR;
		grp_d.last     = byte_in.last_byte;
	end

	// Group state: cleared when a group is emitted, otherwise the byte is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_EMPTY;
			held_q  <= 16'd0;
		end else if (accept) begin
			if (emit) begin
				phase_q <= PHASE_EMPTY;
				held_q  <= 16'd0;
			end else begin
				phase_q <= phase + 2'd1;
				held_q  <= {held_q[7:0], byte_in.data_byte};
			end
		end
	end

	// Result register towards the character emitter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
		end else if (accept && emit) begin
			grp_valid_q <= 1'b1;
		end else if (grp_ready) begin
			grp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			grp_q <= grp_d;
		end
	end

	assign grp       = grp_q;
	assign grp_valid = grp_valid_q;

endmodule

>>> src/b64e_emit.sv
// Character emitter: holds one group of four characters and sends them
// one per transfer. Depends on b64e_pkg and b64e_if.
module b64e_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::grp_t   grp,
	input  logic             grp_valid,
	output logic             grp_ready,
	b64e_char_if.source      char_out
);
	import b64e_pkg::*;

	logic [3:0][7:0] chars_q;
	logic            last_q;
	logic [1:0]      idx_q;
	logic            busy_q;

	logic            xfer;
	logic            load;

	assign xfer      = busy_q && char_out.ready;
	assign grp_ready = !busy_q || (xfer && (idx_q == LAST_SLOT));
	assign load      = grp_valid && grp_ready;

	// Slot counter and busy flag; a new group follows the last slot at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (xfer) begin
			if (idx_q == LAST_SLOT) begin
				busy_q <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Group payload.
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= grp.chars;
			last_q  <= grp.last;
		end
	end

	// The message end is marked on the final slot of a flagged group.
	assign char_out.valid     = busy_q;
	assign char_out.out_char  = chars_q[idx_q];
	assign char_out.last_char = last_q && (idx_q == LAST_SLOT);

endmodule
